>>> src/qau_pkg.sv
// Shared constants, operation and status codes and transfer types of the quaternion unit.
package qau_pkg;

  localparam int DATA_W         = 32;
  localparam int FRAC_BITS      = 16;
  localparam int PROD_W         = 2 * DATA_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int POS_W          = $clog2(DATA_W);
  localparam int NORM_MSB       = 29;
  localparam int U_W            = NORM_MSB + 1;
  localparam int SQ_W           = 2 * U_W;
  localparam int SS_W           = SQ_W + 2;
  localparam int ROOT_W         = SS_W / 2;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = (ROOT_W + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
  localparam int SQRT_STEPS     = SQRT_STAGES * SQRT_PER_STAGE;
  localparam int DVD_W          = DATA_W + FRAC_BITS;
  localparam int DIV_PER_STAGE  = 2;
  localparam int DIV_STAGES     = (DVD_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int DIV_STEPS      = DIV_STAGES * DIV_PER_STAGE;

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_SCALE = 3'd3,
    OP_DIV   = 3'd4,
    OP_DOT   = 3'd5,
    OP_NORM  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] a_w;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
    logic signed [DATA_W-1:0] b_w;
    logic signed [DATA_W-1:0] scalar_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [DATA_W-1:0] r_z;
    logic signed [DATA_W-1:0] r_w;
    logic signed [DATA_W-1:0] scalar_out;
    logic [1:0]               status;
  } out_item_t;

endpackage

>>> src/qau_sqrt.sv
// Pipelined digit-by-digit integer square root, floor of the root of the radicand.
module qau_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [qau_pkg::SS_W-1:0]    rad_i,
  output logic [qau_pkg::ROOT_W-1:0]  root_o
);

  localparam int STAGES = qau_pkg::SQRT_STAGES;
  localparam int PER    = qau_pkg::SQRT_PER_STAGE;
  localparam int STEPS  = qau_pkg::SQRT_STEPS;
  localparam int RAD_W  = 2 * STEPS;
  localparam int REM_W  = STEPS + 3;

  logic [REM_W-1:0] rem_q  [STAGES];
  logic [STEPS-1:0] root_q [STAGES];
  logic [RAD_W-1:0] rad_q  [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [REM_W-1:0] rem_in, rem_d, trial;
    logic [STEPS-1:0] root_in, root_d;
    logic [RAD_W-1:0] rad_in, rad_d;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = RAD_W'(rad_i);
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
    end

    // Each step brings down two radicand bits and tries the next root bit.
    always_comb begin
      rem_d  = rem_in;
      root_d = root_in;
      rad_d  = rad_in;
      trial  = '0;
      for (int s = 0; s < PER; s++) begin
        rem_d = {rem_d[REM_W-3:0], rad_d[RAD_W-1 -: 2]};
        rad_d = rad_d << 2;
        trial = REM_W'({root_d, 2'b01});
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[STEPS-2:0], 1'b1};
        end else begin
          root_d = {root_d[STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        rad_q[g]  <= rad_d;
      end
    end
  end

  assign root_o = root_q[STAGES-1][qau_pkg::ROOT_W-1:0];

endmodule

>>> src/qau_div.sv
// Pipelined unsigned restoring divider, quotient truncated toward zero.
module qau_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [qau_pkg::DVD_W-1:0]    dvd_i,
  input  logic [qau_pkg::DATA_W-1:0]   dsor_i,
  output logic [qau_pkg::DVD_W-1:0]    quo_o
);

  localparam int W      = qau_pkg::DATA_W;
  localparam int STAGES = qau_pkg::DIV_STAGES;
  localparam int PER    = qau_pkg::DIV_PER_STAGE;
  localparam int STEPS  = qau_pkg::DIV_STEPS;
  localparam int REM_W  = W + 1;

  logic [STEPS-1:0] num_q  [STAGES];
  logic [STEPS-1:0] quo_q  [STAGES];
  logic [REM_W-1:0] rem_q  [STAGES];
  logic [W-1:0]     dsor_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [STEPS-1:0] num_in, num_d, quo_in, quo_d;
    logic [REM_W-1:0] rem_in, rem_d;
    logic [W-1:0]     dsor_in;

    if (g == 0) begin : g_first
      assign num_in  = STEPS'(dvd_i);
      assign quo_in  = '0;
      assign rem_in  = '0;
      assign dsor_in = dsor_i;
    end else begin : g_next
      assign num_in  = num_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign dsor_in = dsor_q[g-1];
    end

    always_comb begin
      num_d = num_in;
      quo_d = quo_in;
      rem_d = rem_in;
      for (int s = 0; s < PER; s++) begin
        rem_d = {rem_d[REM_W-2:0], num_d[STEPS-1]};
        num_d = num_d << 1;
        if (rem_d >= {1'b0, dsor_in}) begin
          rem_d = rem_d - {1'b0, dsor_in};
          quo_d = {quo_d[STEPS-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[g]  <= num_d;
        quo_q[g]  <= quo_d;
        rem_q[g]  <= rem_d;
        dsor_q[g] <= dsor_in;
      end
    end
  end

  assign quo_o = quo_q[STAGES-1][qau_pkg::DVD_W-1:0];

endmodule

>>> src/quaternion_arithmetic_unit_top.sv
// Quaternion arithmetic unit in signed Q16.16: product, add, subtract, scale, divide, dot, normalise.
// Every item passes through the front stages, the 16-stage square-root pipeline and the 24-stage
// divider, then the final register and the output register.
// Throughput: one item per cycle; a full output plus skid register stalls the whole pipeline.
// Reset: asynchronous and active low; it clears all valid bits and the output handshake state.
module quaternion_arithmetic_unit_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qau_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qau_pkg::out_item_t  out_data_o
);

  localparam int W     = qau_pkg::DATA_W;
  localparam int F     = qau_pkg::FRAC_BITS;
  localparam int SUM_W = qau_pkg::SUM_W;
  localparam int POS_W = qau_pkg::POS_W;
  localparam int U_W   = qau_pkg::U_W;
  localparam int SQ    = qau_pkg::SQRT_STAGES;
  localparam int DV    = qau_pkg::DIV_STAGES;
  localparam int PRE   = 7;
  localparam logic [POS_W-1:0] NORM_POS = POS_W'(qau_pkg::NORM_MSB);

  typedef struct packed {
    logic [2:0]          op;
    logic [3:0][W-1:0]   mag;
    logic [3:0]          neg;
    logic [W-1:0]        smag;
    logic                sneg;
    logic                szero;
  } ctx_t;

  typedef struct packed {
    logic [3:0][W-1:0]   r;
    logic [W-1:0]        so;
    logic [1:0]          st;
    logic                sat;
  } res_t;

  typedef struct packed {
    logic [2:0]          op;
    res_t                res;
    logic [3:0][W-1:0]   num;
    logic [3:0]          neg;
    logic [W-1:0]        dsor;
  } side_t;

  function automatic logic [W:0] sat_fn(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-W:0] hi;
    hi = v[SUM_W-1:W-1];
    if ((&hi) || !(|hi)) begin
      return {1'b0, v[W-1:0]};
    end else if (v[SUM_W-1]) begin
      return {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // Handshake and stall control.
  logic en, push, pop;
  logic [PRE-1:0] pv_q;
  logic [SQ-1:0]  sv_q;
  logic [DV-1:0]  dv_q;
  logic           fv_q;
  logic           out_v_q, out_v_d, skid_v_q, skid_v_d;
  qau_pkg::out_item_t out_q, skid_q, fin_q, fin_d;

  assign en          = !skid_v_q;
  assign in_ready_o  = en;
  assign push        = en && fv_q;
  assign pop         = out_v_q && out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Stage 1: input register.
  qau_pkg::in_item_t in_q;
  logic signed [W-1:0] a1 [4];
  logic signed [W-1:0] b1 [4];
  logic signed [W-1:0] s1;

  assign a1[0] = in_q.a_x;
  assign a1[1] = in_q.a_y;
  assign a1[2] = in_q.a_z;
  assign a1[3] = in_q.a_w;
  assign b1[0] = in_q.b_x;
  assign b1[1] = in_q.b_y;
  assign b1[2] = in_q.b_z;
  assign b1[3] = in_q.b_w;
  assign s1    = in_q.scalar_in;

  // Stage 2: all sixteen cross products; scaling reuses the diagonal multipliers.
  logic signed [qau_pkg::PROD_W-1:0] p2_d [4][4];
  logic signed [qau_pkg::PROD_W-1:0] p2_q [4][4];
  logic signed [W:0] as2_d [4];
  logic signed [W:0] as2_q [4];
  ctx_t ctx2_d, ctx2_q;

  always_comb begin
    logic signed [W-1:0] mb;
    mb     = '0;
    ctx2_d = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        mb = (in_q.operation == qau_pkg::OP_SCALE && i == j) ? s1 : b1[j];
        p2_d[i][j] = a1[i] * mb;
      end
      as2_d[i]       = (in_q.operation == qau_pkg::OP_SUB) ? a1[i] - b1[i] : a1[i] + b1[i];
      ctx2_d.mag[i]  = a1[i][W-1] ? (~a1[i] + 1'b1) : a1[i];
      ctx2_d.neg[i]  = a1[i][W-1];
    end
    ctx2_d.op    = in_q.operation;
    ctx2_d.smag  = s1[W-1] ? (~s1 + 1'b1) : s1;
    ctx2_d.sneg  = s1[W-1];
    ctx2_d.szero = (s1 == '0);
  end

  // Stage 3: exact wide sums and the largest magnitude; add and subtract are lifted so that stage 4 treats all alike.
  logic signed [SUM_W-1:0] sum3_d [4];
  logic signed [SUM_W-1:0] sum3_q [4];
  logic signed [SUM_W-1:0] dot3_d, dot3_q;
  logic [W-1:0] m3_d, m3_q;
  ctx_t ctx3_q;

  always_comb begin
    logic [W-1:0] t0, t1;
    case (ctx2_q.op) inside
      qau_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          sum3_d[i] = SUM_W'(p2_q[i][i]);
        end
      end
      qau_pkg::OP_ADD, qau_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          sum3_d[i] = SUM_W'(as2_q[i]) << F;
        end
      end
      default: begin
        sum3_d[0] = p2_q[3][0] + p2_q[0][3] + p2_q[1][2] - p2_q[2][1];
        sum3_d[1] = p2_q[3][1] + p2_q[1][3] + p2_q[2][0] - p2_q[0][2];
        sum3_d[2] = p2_q[3][2] + p2_q[2][3] + p2_q[0][1] - p2_q[1][0];
        sum3_d[3] = p2_q[3][3] - p2_q[0][0] - p2_q[1][1] - p2_q[2][2];
      end
    endcase
    dot3_d = p2_q[0][0] + p2_q[1][1] + p2_q[2][2] + p2_q[3][3];
    t0     = (ctx2_q.mag[0] > ctx2_q.mag[1]) ? ctx2_q.mag[0] : ctx2_q.mag[1];
    t1     = (ctx2_q.mag[2] > ctx2_q.mag[3]) ? ctx2_q.mag[2] : ctx2_q.mag[3];
    m3_d   = (t0 > t1) ? t0 : t1;
  end

  // Stage 4: floor by the fraction width and saturate; flag division by zero; locate the leading one for normalise.
  res_t res4_d, res4_q;
  logic [POS_W-1:0] pos4_d, pos4_q;
  ctx_t ctx4_q;

  always_comb begin
    logic [W:0] t;
    t      = '0;
    res4_d = '0;
    case (ctx3_q.op) inside
      qau_pkg::OP_MUL, qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          t             = sat_fn(sum3_q[i] >>> F);
          res4_d.r[i]   = t[W-1:0];
          res4_d.sat    = res4_d.sat | t[W];
        end
      end
      qau_pkg::OP_DOT: begin
        t          = sat_fn(dot3_q >>> F);
        res4_d.so  = t[W-1:0];
        res4_d.sat = t[W];
      end
      qau_pkg::OP_DIV: begin
        res4_d.st = ctx3_q.szero ? qau_pkg::ST_DIVZ : qau_pkg::ST_OK;
      end
      qau_pkg::OP_NORM: begin
        res4_d.st = (m3_q == '0) ? qau_pkg::ST_DIVZ : qau_pkg::ST_OK;
      end
      default: ;
    endcase
    pos4_d = '0;
    for (int b = 0; b < W; b++) begin
      if (m3_q[b]) begin
        pos4_d = POS_W'(b);
      end
    end
  end

  // Stage 5: bring the largest magnitude into the normalising window.
  logic [U_W-1:0] u5_d [4];
  logic [U_W-1:0] u5_q [4];
  res_t res5_q;
  ctx_t ctx5_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (pos4_q < NORM_POS) begin
        u5_d[i] = U_W'(ctx4_q.mag[i] << (NORM_POS - pos4_q));
      end else begin
        u5_d[i] = U_W'(ctx4_q.mag[i] >> (pos4_q - NORM_POS));
      end
    end
  end

  // Stage 6: squares.
  logic [qau_pkg::SQ_W-1:0] sq6_d [4];
  logic [qau_pkg::SQ_W-1:0] sq6_q [4];
  logic [U_W-1:0] u6_q [4];
  res_t res6_q;
  ctx_t ctx6_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq6_d[i] = u5_q[i] * u5_q[i];
    end
  end

  // Stage 7: sum of squares and the operands the shared dividers will need.
  logic [qau_pkg::SS_W-1:0] ss7_d, ss7_q;
  side_t side7_d, side7_q;

  always_comb begin
    ss7_d        = sq6_q[0] + sq6_q[1] + sq6_q[2] + sq6_q[3];
    side7_d.op   = ctx6_q.op;
    side7_d.res  = res6_q;
    side7_d.dsor = ctx6_q.smag;
    for (int i = 0; i < 4; i++) begin
      if (ctx6_q.op == qau_pkg::OP_NORM) begin
        side7_d.num[i] = W'(u6_q[i]);
        side7_d.neg[i] = ctx6_q.neg[i];
      end else begin
        side7_d.num[i] = ctx6_q.mag[i];
        side7_d.neg[i] = ctx6_q.neg[i] ^ ctx6_q.sneg;
      end
    end
  end

  // Square root, with the side data travelling alongside.
  logic [qau_pkg::ROOT_W-1:0] root;
  side_t sside_q [SQ];

  qau_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (ss7_q),
    .root_o (root)
  );

  // Four divider lanes shared by divide and normalise.
  logic [W-1:0]              dsor;
  logic [qau_pkg::DVD_W-1:0] quo [4];
  side_t dside_q [DV];

  assign dsor = (sside_q[SQ-1].op == qau_pkg::OP_NORM) ? W'(root) : sside_q[SQ-1].dsor;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    qau_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .dvd_i  ({sside_q[SQ-1].num[l], {F{1'b0}}}),
      .dsor_i (dsor),
      .quo_o  (quo[l])
    );
  end

  // Final stage: apply signs, saturate quotients and settle the status.
  always_comb begin
    side_t sd;
    logic [3:0][W-1:0] r;
    logic sat;
    logic [qau_pkg::DVD_W-1:0] q;
    sd  = dside_q[DV-1];
    r   = sd.res.r;
    sat = sd.res.sat;
    q   = '0;
    case (sd.op) inside
      qau_pkg::OP_DIV: begin
        if (sd.res.st != qau_pkg::ST_DIVZ) begin
          for (int i = 0; i < 4; i++) begin
            q = quo[i];
            if (sd.neg[i]) begin
              if ((|q[qau_pkg::DVD_W-1:W]) || (q[W-1] && (|q[W-2:0]))) begin
                r[i] = {1'b1, {(W-1){1'b0}}};
                sat  = 1'b1;
              end else begin
                r[i] = -q[W-1:0];
              end
            end else begin
              if (|q[qau_pkg::DVD_W-1:W-1]) begin
                r[i] = {1'b0, {(W-1){1'b1}}};
                sat  = 1'b1;
              end else begin
                r[i] = q[W-1:0];
              end
            end
          end
        end
      end
      qau_pkg::OP_NORM: begin
        if (sd.res.st != qau_pkg::ST_DIVZ) begin
          for (int i = 0; i < 4; i++) begin
            q    = quo[i];
            r[i] = sd.neg[i] ? -q[W-1:0] : q[W-1:0];
          end
        end
      end
      default: ;
    endcase
    fin_d.r_x        = r[0];
    fin_d.r_y        = r[1];
    fin_d.r_z        = r[2];
    fin_d.r_w        = r[3];
    fin_d.scalar_out = sd.res.so;
    fin_d.status     = (sd.res.st == qau_pkg::ST_OK && sat) ? qau_pkg::ST_SAT : sd.res.st;
  end

  // Datapath registers; they all advance together.
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q    <= in_data_i;
      p2_q    <= p2_d;
      as2_q   <= as2_d;
      ctx2_q  <= ctx2_d;
      sum3_q  <= sum3_d;
      dot3_q  <= dot3_d;
      m3_q    <= m3_d;
      ctx3_q  <= ctx2_q;
      res4_q  <= res4_d;
      pos4_q  <= pos4_d;
      ctx4_q  <= ctx3_q;
      u5_q    <= u5_d;
      res5_q  <= res4_q;
      ctx5_q  <= ctx4_q;
      sq6_q   <= sq6_d;
      u6_q    <= u5_q;
      res6_q  <= res5_q;
      ctx6_q  <= ctx5_q;
      ss7_q   <= ss7_d;
      side7_q <= side7_d;
      sside_q[0] <= side7_q;
      for (int k = 1; k < SQ; k++) begin
        sside_q[k] <= sside_q[k-1];
      end
      dside_q[0] <= sside_q[SQ-1];
      for (int k = 1; k < DV; k++) begin
        dside_q[k] <= dside_q[k-1];
      end
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      sv_q <= '0;
      dv_q <= '0;
      fv_q <= 1'b0;
    end else if (en) begin
      pv_q <= {pv_q[PRE-2:0], in_valid_i};
      sv_q <= {sv_q[SQ-2:0], pv_q[PRE-1]};
      dv_q <= {dv_q[DV-2:0], sv_q[SQ-1]};
      fv_q <= dv_q[DV-1];
    end
  end

  // Output register with a skid entry, so one more transfer is taken while a result waits.
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (pop) begin
        skid_v_d = 1'b0;
      end
    end else if (push) begin
      out_v_d = 1'b1;
      if (out_v_q && !pop) begin
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q && pop) begin
      out_q <= skid_q;
    end else if (push && (!out_v_q || pop)) begin
      out_q <= fin_q;
    end
    if (push && out_v_q && !pop) begin
      skid_q <= fin_q;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a result while the output register is empty");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pv_q) && $stable(sv_q) && $stable(dv_q) && $stable(fv_q))
    else $error("pipeline valid bits moved during a stall");

  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.status == qau_pkg::ST_DIVZ |->
      out_q.r_x == '0 && out_q.r_y == '0 && out_q.r_z == '0 && out_q.r_w == '0 &&
      out_q.scalar_out == '0)
    else $error("divide-by-zero status with a non-zero result");

endmodule

>>> tb/sv/tb_quaternion_arithmetic_unit_top.sv
// Self-checking testbench of the quaternion arithmetic unit: directed table, then random stream.
`timescale 1ns / 100ps

module tb_quaternion_arithmetic_unit_top;

  localparam int N_RANDOM = 450;
  localparam int LATENCY  = 48;

  typedef struct {
    qau_pkg::in_item_t  stim;
    logic               known;
    qau_pkg::out_item_t res;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b1;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  qau_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  qau_pkg::out_item_t out_data_o;

  qau_pkg::out_item_t expected_q[$];
  int        n_fail = 0;
  bit        stim_done = 1'b0;
  bit        hold_rx = 1'b0;
  row_t      dir_rows[$];

  quaternion_arithmetic_unit_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp32(input logic signed [79:0] v, ref bit sat);
    if (v > 80'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -80'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Floor of v / 2^FRAC_BITS; an arithmetic shift rounds toward minus infinity.
  function automatic logic signed [79:0] fx_floor(input logic signed [79:0] v);
    return v >>> qau_pkg::FRAC_BITS;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic qau_pkg::out_item_t quat_result(input qau_pkg::in_item_t it);
    qau_pkg::out_item_t r;
    logic signed [79:0] a[4], b[4], p[4], s, acc;
    logic [63:0] u[4], m, sum, len, q;
    int j, k, lft, rgt;
    bit sat;
    r = '0;
    sat = 1'b0;
    a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z; a[3] = it.a_w;
    b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z; b[3] = it.b_w;
    s = it.scalar_in;
    p = '{default: '0};
    case (it.operation)
      qau_pkg::OP_MUL: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          acc = a[3] * b[i] + b[3] * a[i] + a[j] * b[k] - a[k] * b[j];
          p[i] = clamp32(fx_floor(acc), sat);
        end
        acc = a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2];
        p[3] = clamp32(fx_floor(acc), sat);
      end
      qau_pkg::OP_ADD, qau_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++)
          p[i] = clamp32(it.operation == qau_pkg::OP_ADD ? a[i] + b[i] : a[i] - b[i], sat);
      end
      qau_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) p[i] = clamp32(fx_floor(a[i] * s), sat);
      end
      qau_pkg::OP_DIV: begin
        if (s == 0) r.status = qau_pkg::ST_DIVZ;
        else for (int i = 0; i < 4; i++)
          p[i] = clamp32((a[i] <<< qau_pkg::FRAC_BITS) / s, sat);
      end
      qau_pkg::OP_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2] + a[3] * b[3];
        r.scalar_out = clamp32(fx_floor(acc), sat);
      end
      qau_pkg::OP_NORM: begin
        m = 0;
        for (int i = 0; i < 4; i++) begin
          u[i] = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
          if (u[i] > m) m = u[i];
        end
        if (m == 0) begin
          r.status = qau_pkg::ST_DIVZ;
        end else begin
          lft = 0;
          rgt = 0;
          while (m < (64'd1 << 29)) begin m = m << 1; lft++; end
          while (m >= (64'd1 << 30)) begin m = m >> 1; rgt++; end
          sum = 0;
          for (int i = 0; i < 4; i++) begin
            u[i] = (u[i] << lft) >> rgt;
            sum = sum + u[i] * u[i];
          end
          len = int_sqrt(sum);
          for (int i = 0; i < 4; i++) begin
            q = (u[i] << qau_pkg::FRAC_BITS) / len;
            p[i] = a[i] < 0 ? -80'(q) : 80'(q);
          end
        end
      end
      default: ;
    endcase
    r.r_x = p[0][31:0];
    r.r_y = p[1][31:0];
    r.r_z = p[2][31:0];
    r.r_w = p[3][31:0];
    if (sat && r.status == qau_pkg::ST_OK) r.status = qau_pkg::ST_SAT;
    return r;
  endfunction

  function automatic qau_pkg::in_item_t make_item(input logic [2:0] op, input logic [31:0] ax,
      input logic [31:0] ay, input logic [31:0] az, input logic [31:0] aw,
      input logic [31:0] bv, input logic [31:0] sc);
    qau_pkg::in_item_t it;
    it = '{op, ax, ay, az, aw, bv, ~bv, bv ^ 32'h5A5A_A5A5, -bv, sc};
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1:       return 32'($signed($urandom_range(0, 8)) - 4) << qau_pkg::FRAC_BITS;
      2:       return 32'($signed($urandom_range(0, 131071)) - 65536);
      3:       return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 1) ? 32'd1 : '1;
      default: return $urandom;
    endcase
  endfunction

  // Valid stays high across back-to-back transfers and drops only before an idle gap.
  task automatic send_item(input qau_pkg::in_item_t it, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19));
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(quat_result(it));
  endtask

  // Directed table; results typed in only where they are obvious.
  initial begin
    row_t row;
    qau_pkg::out_item_t zero_res;
    zero_res = '0;
    row = '{make_item(qau_pkg::OP_DIV, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 7, 0),
            1'b1, '{0, 0, 0, 0, 0, qau_pkg::ST_DIVZ}};
    dir_rows.push_back(row);
    row = '{make_item(qau_pkg::OP_NORM, 0, 0, 0, 0, 32'h1234_5678, 5), 1'b1,
            '{0, 0, 0, 0, 0, qau_pkg::ST_DIVZ}};
    dir_rows.push_back(row);
    row = '{make_item(3'd7, '1, 32'h8000_0000, 3, 4, 32'hFFFF_FFFF, '1), 1'b1, zero_res};
    dir_rows.push_back(row);
    row = '{make_item(qau_pkg::OP_ADD, 32'h7FFF_FFFF, 0, 0, 0, 0, 0), 1'b0, zero_res};
    row.stim.b_x = 1;
    row.stim.b_y = 0; row.stim.b_z = 0; row.stim.b_w = 0;
    row.known = 1'b1;
    row.res = '{32'h7FFF_FFFF, 0, 0, 0, 0, qau_pkg::ST_SAT};
    dir_rows.push_back(row);
    row = '{make_item(qau_pkg::OP_SUB, 32'h8000_0000, 0, 0, 0, 0, 0), 1'b0, zero_res};
    row.stim.b_x = 1;
    row.stim.b_y = 0; row.stim.b_z = 0; row.stim.b_w = 0;
    row.known = 1'b1;
    row.res = '{32'h8000_0000, 0, 0, 0, 0, qau_pkg::ST_SAT};
    dir_rows.push_back(row);
    for (int op = 0; op < 7; op++) begin
      dir_rows.push_back('{make_item(op[2:0], 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
                           1'b0, zero_res});
      dir_rows.push_back('{make_item(op[2:0], 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 1,
                                     32'h0000_C000, 32'h0003_0000), 1'b0, zero_res});
    end
    dir_rows.push_back('{make_item(qau_pkg::OP_NORM, 0, 0, 0, 1, 0, 0), 1'b0, zero_res});
    dir_rows.push_back('{make_item(qau_pkg::OP_SCALE, '1, 32'h8000_0000, 1, 32'h7FFF_FFFF, 0,
                                   32'hFFFF_FFFF), 1'b0, zero_res});
  end

  initial begin
    qau_pkg::in_item_t it;
    bit burst;
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].stim, 1'b0);
      if (dir_rows[i].known && expected_q[$] != dir_rows[i].res) begin
        $error("table row %0d: expected %h, predicted %h", i, dir_rows[i].res, expected_q[$]);
        n_fail++;
      end
    end
    in_valid_i <= 1'b0;
    // Pause until every outstanding transfer has drained.
    while (expected_q.size() != 0) @(posedge clk_i);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 100) hold_rx = 1'b1;
      if (n == 200) hold_rx = 1'b0;
      burst = (n >= 100 && n < 200);
      it.operation = $urandom_range(0, 12) == 0 ? 3'd7 : 3'($urandom_range(0, 6));
      it.a_x = rand_word(); it.a_y = rand_word(); it.a_z = rand_word(); it.a_w = rand_word();
      it.b_x = rand_word(); it.b_y = rand_word(); it.b_z = rand_word(); it.b_w = rand_word();
      it.scalar_in = rand_word();
      send_item(it, burst);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps pushing.
  initial begin
    int stall;
    int held;
    bit hold_done;
    hold_done = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_rx && !hold_done) begin
        out_ready_i <= 1'b0;
        held = 0;
        while (held < 300) begin
          @(posedge clk_i);
          held++;
        end
        hold_done = 1'b1;
      end
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    qau_pkg::out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data_o);
        n_fail++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data_o.r_x !== exp_r.r_x) begin
          $error("r_x: expected %h, got %h", exp_r.r_x, out_data_o.r_x); n_fail++;
        end
        if (out_data_o.r_y !== exp_r.r_y) begin
          $error("r_y: expected %h, got %h", exp_r.r_y, out_data_o.r_y); n_fail++;
        end
        if (out_data_o.r_z !== exp_r.r_z) begin
          $error("r_z: expected %h, got %h", exp_r.r_z, out_data_o.r_z); n_fail++;
        end
        if (out_data_o.r_w !== exp_r.r_w) begin
          $error("r_w: expected %h, got %h", exp_r.r_w, out_data_o.r_w); n_fail++;
        end
        if (out_data_o.scalar_out !== exp_r.scalar_out) begin
          $error("scalar_out: expected %h, got %h", exp_r.scalar_out, out_data_o.scalar_out);
          n_fail++;
        end
        if (out_data_o.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_data_o.status); n_fail++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> quaternion_arithmetic_unit_top.f
src/qau_pkg.sv
src/qau_sqrt.sv
src/qau_div.sv
src/quaternion_arithmetic_unit_top.sv
tb/sv/tb_quaternion_arithmetic_unit_top.sv
